FILE: hdl/assert_macros.svh
// assertion macros shared by the list unit modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

FILE: hdl/iol_pkg.sv
// shared types and constants of the indexed ordered list unit
// no dependencies
package iol_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int ITEM_W   = 16;
  localparam int FRAC_W   = 8;
  localparam int SUM_W    = ITEM_W + CNT_W - 1;
  localparam int DIVD_W   = SUM_W + FRAC_W;
  localparam int MEAN_W   = 24;
  localparam int STEP_W   = 5;
  localparam int CMD_W    = 3;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 80;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_AVG    = 3'd5
  } cmd_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_PUSH,
    OP_POP,
    OP_REMOVE,
    OP_GET_RD,
    OP_GET_CAP,
    OP_CLEAR,
    OP_SUM_START,
    OP_SH_RD,
    OP_SH_WR,
    OP_SH_END,
    OP_SUM_RD,
    OP_SUM_ACC,
    OP_DIV_START,
    OP_DIV_CAP,
    OP_FR_RD,
    OP_BK_RD,
    OP_BK_CAP,
    OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cnt_zero;
    logic             cnt_full;
    logic             pos_ok;
    logic             shift_more;
    logic             sum_more;
    logic             div_busy;
  } stat_t;

endpackage

FILE: hdl/iol_div.sv
// restoring divider for the average: one quotient bit per cycle
// depends on iol_pkg
`include "assert_macros.svh"

module iol_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [iol_pkg::DIVD_W-1:0]  dividend,
  input  logic [iol_pkg::CNT_W-1:0]   divisor,
  output logic                        busy,
  output logic [iol_pkg::MEAN_W-1:0]  quotient
);

  logic                        busy_r, busy_nxt;
  logic [iol_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [iol_pkg::DIVD_W-1:0]  quot_r, quot_nxt;
  logic [iol_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [iol_pkg::CNT_W-1:0]   dvsr_r, dvsr_nxt;
  logic [iol_pkg::CNT_W:0]     shifted;
  logic [iol_pkg::CNT_W:0]     diff;
  logic                        fits;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    shifted  = {rem_r, quot_r[iol_pkg::DIVD_W-1]};
    diff     = shifted - {1'b0, dvsr_r};
    fits     = (shifted >= {1'b0, dvsr_r});
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[iol_pkg::CNT_W-1:0] : shifted[iol_pkg::CNT_W-1:0];
      quot_nxt = {quot_r[iol_pkg::DIVD_W-2:0], fits};
      step_nxt = step_r + iol_pkg::STEP_W'(1);
      if (step_r == iol_pkg::STEP_W'(iol_pkg::DIVD_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    step_r <= step_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quot_r[iol_pkg::MEAN_W-1:0];

  // partial remainder stays below the divisor throughout
  `ASSERT_NEVER(a_div_rem, busy_r && (rem_r >= dvsr_r), "divider remainder out of range")

endmodule

FILE: hdl/iol_dp.sv
// datapath: item memory, count, walk index, sum, result registers
// depends on iol_pkg and iol_div
`include "assert_macros.svh"

module iol_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  iol_pkg::ctrl_t              ctrl,
  output iol_pkg::stat_t              stat,
  input  logic                        cfg_we,
  input  logic [iol_pkg::ITEM_W-1:0]  cfg_value,
  input  logic [iol_pkg::CMD_W-1:0]   in_cmd,
  input  logic [iol_pkg::ITEM_W-1:0]  in_value,
  input  logic [iol_pkg::IDX_W-1:0]   in_position,
  output logic [iol_pkg::ITEM_W-1:0]  out_data,
  output logic                        out_ok,
  output logic [iol_pkg::CNT_W-1:0]   out_count,
  output logic [iol_pkg::ITEM_W-1:0]  out_front,
  output logic [iol_pkg::ITEM_W-1:0]  out_back,
  output logic [iol_pkg::MEAN_W-1:0]  out_mean
);

  logic [iol_pkg::ITEM_W-1:0] mem [iol_pkg::DEPTH];
  logic [iol_pkg::ITEM_W-1:0] rdata_r;

  logic [iol_pkg::ITEM_W-1:0] empty_value_r;
  logic [iol_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [iol_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [iol_pkg::ITEM_W-1:0] val_r, val_nxt;
  logic [iol_pkg::IDX_W-1:0]  pos_r, pos_nxt;
  logic [iol_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [iol_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [iol_pkg::ITEM_W-1:0] data_r, data_nxt;
  logic                       ok_r, ok_nxt;
  logic [iol_pkg::MEAN_W-1:0] mean_r, mean_nxt;
  logic [iol_pkg::ITEM_W-1:0] front_r, front_nxt;
  logic [iol_pkg::ITEM_W-1:0] back_r, back_nxt;

  logic [iol_pkg::ITEM_W-1:0] out_data_r, out_front_r, out_back_r;
  logic                       out_ok_r;
  logic [iol_pkg::CNT_W-1:0]  out_count_r;
  logic [iol_pkg::MEAN_W-1:0] out_mean_r;
  logic                       load_out;

  logic                       mem_we;
  logic [iol_pkg::IDX_W-1:0]  waddr, raddr;
  logic [iol_pkg::ITEM_W-1:0] wdata;
  logic [iol_pkg::CNT_W-1:0]  idx_inc;
  logic [iol_pkg::CNT_W-1:0]  last_idx;

  logic                       div_start;
  logic                       div_busy;
  logic [iol_pkg::MEAN_W-1:0] div_quot;

  iol_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, {iol_pkg::FRAC_W{1'b0}}}),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign idx_inc  = idx_r + iol_pkg::CNT_W'(1);
  assign last_idx = cnt_r - iol_pkg::CNT_W'(1);

  always_comb begin
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    data_nxt  = data_r;
    ok_nxt    = ok_r;
    mean_nxt  = mean_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    mem_we    = 1'b0;
    waddr     = cnt_r[iol_pkg::IDX_W-1:0];
    wdata     = val_r;
    raddr     = '0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (ctrl.op)
      iol_pkg::OP_LATCH: begin
        cmd_nxt  = in_cmd;
        val_nxt  = in_value;
        pos_nxt  = in_position;
        data_nxt = empty_value_r;
        ok_nxt   = 1'b0;
        mean_nxt = '0;
      end
      iol_pkg::OP_PUSH: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + iol_pkg::CNT_W'(1);
        ok_nxt  = 1'b1;
      end
      iol_pkg::OP_POP: begin
        data_nxt = front_r;
        ok_nxt   = 1'b1;
        idx_nxt  = '0;
      end
      iol_pkg::OP_REMOVE: begin
        ok_nxt  = 1'b1;
        idx_nxt = {1'b0, pos_r};
      end
      iol_pkg::OP_GET_RD: begin
        raddr  = pos_r;
        ok_nxt = 1'b1;
      end
      iol_pkg::OP_GET_CAP: begin
        data_nxt = rdata_r;
      end
      iol_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
        ok_nxt  = 1'b1;
      end
      iol_pkg::OP_SUM_START: begin
        sum_nxt = '0;
        idx_nxt = '0;
        ok_nxt  = 1'b1;
      end
      iol_pkg::OP_SH_RD: begin
        raddr = idx_inc[iol_pkg::IDX_W-1:0];
      end
      iol_pkg::OP_SH_WR: begin
        mem_we  = 1'b1;
        waddr   = idx_r[iol_pkg::IDX_W-1:0];
        wdata   = rdata_r;
        idx_nxt = idx_inc;
      end
      iol_pkg::OP_SH_END: begin
        cnt_nxt = last_idx;
      end
      iol_pkg::OP_SUM_RD: begin
        raddr = idx_r[iol_pkg::IDX_W-1:0];
      end
      iol_pkg::OP_SUM_ACC: begin
        sum_nxt = sum_r + iol_pkg::SUM_W'(rdata_r);
        idx_nxt = idx_inc;
      end
      iol_pkg::OP_DIV_START: begin
        div_start = 1'b1;
      end
      iol_pkg::OP_DIV_CAP: begin
        mean_nxt = div_quot;
      end
      iol_pkg::OP_FR_RD: begin
        raddr = '0;
      end
      iol_pkg::OP_BK_RD: begin
        front_nxt = rdata_r;
        raddr     = last_idx[iol_pkg::IDX_W-1:0];
      end
      iol_pkg::OP_BK_CAP: begin
        back_nxt = rdata_r;
      end
      iol_pkg::OP_LOAD_OUT: begin
        load_out = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // item memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      empty_value_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        empty_value_r <= cfg_value;
      end
    end
    cmd_r   <= cmd_nxt;
    val_r   <= val_nxt;
    pos_r   <= pos_nxt;
    idx_r   <= idx_nxt;
    sum_r   <= sum_nxt;
    data_r  <= data_nxt;
    ok_r    <= ok_nxt;
    mean_r  <= mean_nxt;
    front_r <= front_nxt;
    back_r  <= back_nxt;
    if (load_out) begin
      out_data_r  <= data_r;
      out_ok_r    <= ok_r;
      out_count_r <= cnt_r;
      out_front_r <= (cnt_r == '0) ? empty_value_r : front_r;
      out_back_r  <= (cnt_r == '0) ? empty_value_r : back_r;
      out_mean_r  <= mean_r;
    end
  end

  always_comb begin
    stat.cmd        = cmd_r;
    stat.cnt_zero   = (cnt_r == '0);
    stat.cnt_full   = (cnt_r == iol_pkg::CNT_W'(iol_pkg::DEPTH));
    stat.pos_ok     = ({1'b0, pos_r} < cnt_r);
    stat.shift_more = (idx_inc < cnt_r);
    stat.sum_more   = (idx_r < cnt_r);
    stat.div_busy   = div_busy;
  end

  assign out_data  = out_data_r;
  assign out_ok    = out_ok_r;
  assign out_count = out_count_r;
  assign out_front = out_front_r;
  assign out_back  = out_back_r;
  assign out_mean  = out_mean_r;

  `ASSERT_NEVER(a_cnt_range, cnt_r > iol_pkg::CNT_W'(iol_pkg::DEPTH), "item count above depth")

endmodule

FILE: hdl/iol_ctrl.sv
// controller: sequences each command through the datapath, owns out_tvalid
// depends on iol_pkg
`include "assert_macros.svh"

module iol_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  iol_pkg::stat_t  stat,
  output iol_pkg::ctrl_t  ctrl
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_DECODE  = 13'b0000000000010,
    S_GET     = 13'b0000000000100,
    S_SH_RD   = 13'b0000000001000,
    S_SH_WR   = 13'b0000000010000,
    S_SUM_RD  = 13'b0000000100000,
    S_SUM_ACC = 13'b0000001000000,
    S_DIV     = 13'b0000010000000,
    S_FR_RD   = 13'b0000100000000,
    S_BK_RD   = 13'b0001000000000,
    S_BK_CAP  = 13'b0010000000000,
    S_DONE    = 13'b0100000000000,
    S_SPARE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    ctrl.op       = iol_pkg::OP_NONE;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.op   = iol_pkg::OP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FR_RD;
        case (stat.cmd)
          iol_pkg::CMD_PUSH: begin
            if (!stat.cnt_full) begin
              ctrl.op = iol_pkg::OP_PUSH;
            end
          end
          iol_pkg::CMD_POP: begin
            if (!stat.cnt_zero) begin
              ctrl.op   = iol_pkg::OP_POP;
              state_nxt = S_SH_RD;
            end
          end
          iol_pkg::CMD_REMOVE: begin
            if (stat.pos_ok) begin
              ctrl.op   = iol_pkg::OP_REMOVE;
              state_nxt = S_SH_RD;
            end
          end
          iol_pkg::CMD_GET: begin
            if (stat.pos_ok) begin
              ctrl.op   = iol_pkg::OP_GET_RD;
              state_nxt = S_GET;
            end
          end
          iol_pkg::CMD_CLEAR: begin
            ctrl.op = iol_pkg::OP_CLEAR;
          end
          iol_pkg::CMD_AVG: begin
            if (!stat.cnt_zero) begin
              ctrl.op   = iol_pkg::OP_SUM_START;
              state_nxt = S_SUM_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_GET: begin
        ctrl.op   = iol_pkg::OP_GET_CAP;
        state_nxt = S_FR_RD;
      end
      S_SH_RD: begin
        if (stat.shift_more) begin
          ctrl.op   = iol_pkg::OP_SH_RD;
          state_nxt = S_SH_WR;
        end else begin
          ctrl.op   = iol_pkg::OP_SH_END;
          state_nxt = S_FR_RD;
        end
      end
      S_SH_WR: begin
        ctrl.op   = iol_pkg::OP_SH_WR;
        state_nxt = S_SH_RD;
      end
      S_SUM_RD: begin
        if (stat.sum_more) begin
          ctrl.op   = iol_pkg::OP_SUM_RD;
          state_nxt = S_SUM_ACC;
        end else begin
          ctrl.op   = iol_pkg::OP_DIV_START;
          state_nxt = S_DIV;
        end
      end
      S_SUM_ACC: begin
        ctrl.op   = iol_pkg::OP_SUM_ACC;
        state_nxt = S_SUM_RD;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          ctrl.op   = iol_pkg::OP_DIV_CAP;
          state_nxt = S_FR_RD;
        end
      end
      S_FR_RD: begin
        ctrl.op   = iol_pkg::OP_FR_RD;
        state_nxt = S_BK_RD;
      end
      S_BK_RD: begin
        ctrl.op   = iol_pkg::OP_BK_RD;
        state_nxt = S_BK_CAP;
      end
      S_BK_CAP: begin
        ctrl.op   = iol_pkg::OP_BK_CAP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait until the output register is empty or being drained
        if (slot_free) begin
          ctrl.op       = iol_pkg::OP_LOAD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `ASSERT_CLK(a_accept_decode, (in_tvalid && in_tready) |=> (state_r == S_DECODE), "accepted word not decoded")
  `ASSERT_CLK(a_done_holds, (state_r == S_DONE && out_valid_r && !out_tready) |=> (state_r == S_DONE), "result loaded over a pending word")

endmodule

FILE: hdl/indexed_ordered_list_unit.sv
// Indexed ordered list unit
// Holds up to 64 16-bit items in a single-port-write, registered-read memory.
// Input word: in_tuser carries the command (push_back, pop_front, remove_at,
// get_at, clear, average); in_tdata carries the value and the position.
// Each input word gives exactly one output word with the item read, the
// count, front and back items and the Q16.8 average; out_tuser is the ok flag.
// cfg_data written over cfg_valid/cfg_ready sets the value reported for an
// empty list or an out-of-range index; write it only while the unit is idle.
// One word is in flight at a time; the next word is accepted in the cycle after
// the result is loaded. After decode, push, clear and failed commands go on to
// the front and back reads; get_at first captures the item read; pop and
// remove_at move each later entry down one place; average sums the entries,
// then waits for the one-bit-per-cycle divider. The moving and summing loops
// take each entry through the memory read port, in a read state and then a
// write or add state. A new word is accepted while the previous result still
// waits in the output register; a stalled receiver holds the result and, once
// the next result is ready, holds back further work. Reset (rst_n, synchronous)
// empties the list and clears the empty value to zero.
// depends on iol_pkg, iol_ctrl, iol_dp

module indexed_ordered_list_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [iol_pkg::IN_DW-1:0]    in_tdata,   // value[15:0], position[21:16], zero pad
  input  logic [iol_pkg::CMD_W-1:0]    in_tuser,   // cmd[2:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [iol_pkg::OUT_DW-1:0]   out_tdata,  // data, count, front_item, back_item, mean_q8, pad
  output logic                         out_tuser,  // ok
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [iol_pkg::ITEM_W-1:0]   cfg_data    // empty_value
);

  iol_pkg::ctrl_t              ctrl;
  iol_pkg::stat_t              stat;
  logic [iol_pkg::ITEM_W-1:0]  o_data, o_front, o_back;
  logic                        o_ok;
  logic [iol_pkg::CNT_W-1:0]   o_count;
  logic [iol_pkg::MEAN_W-1:0]  o_mean;

  assign cfg_ready = 1'b1;

  iol_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  iol_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .cfg_we      (cfg_valid),
    .cfg_value   (cfg_data),
    .in_cmd      (in_tuser),
    .in_value    (in_tdata[15:0]),
    .in_position (in_tdata[21:16]),
    .out_data    (o_data),
    .out_ok      (o_ok),
    .out_count   (o_count),
    .out_front   (o_front),
    .out_back    (o_back),
    .out_mean    (o_mean)
  );

  assign out_tdata = {1'b0, o_mean, o_back, o_front, o_count, o_data};
  assign out_tuser = o_ok;

endmodule

FILE: tb/testbench.sv
// self-checking bench for indexed_ordered_list_unit: drives command words with random
// gaps and receiver stalls, predicts each result from a shadow copy of the list
// depends on iol_pkg and indexed_ordered_list_unit
module testbench;
  import iol_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 200;
  localparam int GAP_MAX = 18;

  typedef struct packed {
    logic [ITEM_W-1:0] data;
    logic              ok;
    logic [CNT_W-1:0]  count;
    logic [ITEM_W-1:0] front;
    logic [ITEM_W-1:0] back;
    logic [MEAN_W-1:0] mean;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic [CMD_W-1:0]    in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ITEM_W-1:0]   cfg_data = '0;

  // shadow of the list contents and the reported empty value
  logic [ITEM_W-1:0]   shadow_list[$];
  logic [ITEM_W-1:0]   shadow_empty = '0;
  list_result_t        pending_results[$];

  int fail_cnt = 0;
  int idle_cycles = 0;
  int tx_gap_max = GAP_MAX;
  int rx_gap_max = GAP_MAX;
  int rx_hold_cycles = 0;

  indexed_ordered_list_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] cmd,
                                                  logic [ITEM_W-1:0] value,
                                                  logic [IDX_W-1:0] pos);
    list_result_t r;
    logic [63:0] sum;
    logic [63:0] mean_full;
    r = '0;
    r.data = shadow_empty;
    case (cmd)
      CMD_PUSH: if (shadow_list.size() < DEPTH) begin
        shadow_list.push_back(value);
        r.ok = 1'b1;
      end
      CMD_POP: if (shadow_list.size() > 0) begin
        r.data = shadow_list.pop_front();
        r.ok = 1'b1;
      end
      CMD_REMOVE: if (pos < shadow_list.size()) begin
        shadow_list.delete(int'(pos));
        r.ok = 1'b1;
      end
      CMD_GET: if (pos < shadow_list.size()) begin
        r.data = shadow_list[pos];
        r.ok = 1'b1;
      end
      CMD_CLEAR: begin
        shadow_list.delete();
        r.ok = 1'b1;
      end
      CMD_AVG: if (shadow_list.size() > 0) begin
        sum = '0;
        foreach (shadow_list[i]) sum += shadow_list[i];
        mean_full = (sum << FRAC_W) / shadow_list.size();
        r.mean = mean_full[MEAN_W-1:0];
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_list.size());
    r.front = shadow_list.size() > 0 ? shadow_list[0] : shadow_empty;
    r.back  = shadow_list.size() > 0 ? shadow_list[shadow_list.size() - 1] : shadow_empty;
    return r;
  endfunction

  // one command word; the gap after it is drawn here so valid stays high when it is 0
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ITEM_W-1:0] value,
                          input logic [IDX_W-1:0] pos);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, pos, value};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_list_cmd(cmd, value, pos));
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_empty_value(input logic [ITEM_W-1:0] v);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_empty = v;
    @(posedge clk);
  endtask

  function automatic logic [ITEM_W-1:0] rand_item();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return 16'h8000;
      default: return ITEM_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // mostly in range so remove and get do real work
  function automatic logic [IDX_W-1:0] pick_position();
    if (shadow_list.size() > 0 && $urandom_range(0, 99) < 80)
      return IDX_W'($urandom_range(0, shadow_list.size() - 1));
    return IDX_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(int push_pct);
    int r;
    if ($urandom_range(0, 99) < push_pct) return CMD_PUSH;
    r = $urandom_range(0, 99);
    if (r < 28) return CMD_POP;
    if (r < 50) return CMD_REMOVE;
    if (r < 74) return CMD_GET;
    if (r < 90) return CMD_AVG;
    if (r < 92) return CMD_CLEAR;
    if (r < 96) return CMD_UNUSED6;
    return CMD_UNUSED7;
  endfunction

  task automatic test_empty_list();
    send_cmd(CMD_POP, 16'h1234, 6'd0);
    send_cmd(CMD_GET, 16'h0000, 6'd0);
    send_cmd(CMD_GET, 16'hFFFF, 6'd63);
    send_cmd(CMD_REMOVE, 16'h0000, 6'd0);
    send_cmd(CMD_REMOVE, 16'h0000, 6'd63);
    send_cmd(CMD_AVG, 16'h0000, 6'd0);
    send_cmd(CMD_CLEAR, 16'h0000, 6'd0);
    send_cmd(CMD_UNUSED6, 16'hFFFF, 6'd63);
    send_cmd(CMD_UNUSED7, 16'h5555, 6'd21);
  endtask

  task automatic test_basic_ops();
    write_empty_value(16'hFFFF);
    send_cmd(CMD_POP, 16'h0000, 6'd0);
    send_cmd(CMD_PUSH, 16'hFFFF, 6'd0);
    send_cmd(CMD_PUSH, 16'h0000, 6'd0);
    send_cmd(CMD_PUSH, 16'h8001, 6'd63);
    send_cmd(CMD_GET, 16'h0000, 6'd1);
    send_cmd(CMD_GET, 16'h0000, 6'd3);
    send_cmd(CMD_AVG, 16'h0000, 6'd0);
    send_cmd(CMD_REMOVE, 16'h0000, 6'd1);
    send_cmd(CMD_REMOVE, 16'h0000, 6'd2);
    send_cmd(CMD_POP, 16'h0000, 6'd0);
    send_cmd(CMD_AVG, 16'h0000, 6'd0);
    send_cmd(CMD_REMOVE, 16'h0000, 6'd0);
    send_cmd(CMD_AVG, 16'h0000, 6'd0);
    send_cmd(CMD_CLEAR, 16'h0000, 6'd0);
  endtask

  // all-ones fill gives the largest possible mean
  task automatic test_full_list();
    write_empty_value(16'h5A5A);
    send_cmd(CMD_CLEAR, 16'h0000, 6'd0);
    repeat (DEPTH) send_cmd(CMD_PUSH, 16'hFFFF, 6'd0);
    send_cmd(CMD_PUSH, 16'h0001, 6'd0);
    send_cmd(CMD_AVG, 16'h0000, 6'd0);
    send_cmd(CMD_GET, 16'h0000, 6'd63);
    send_cmd(CMD_REMOVE, 16'h0000, 6'd0);
    send_cmd(CMD_PUSH, 16'h0000, 6'd0);
    send_cmd(CMD_GET, 16'h0000, 6'd63);
    send_cmd(CMD_REMOVE, 16'h0000, 6'd63);
    send_cmd(CMD_AVG, 16'h0000, 6'd0);
    send_cmd(CMD_POP, 16'h0000, 6'd0);
  endtask

  // receiver holds off while words keep coming back to back
  task automatic test_output_stall();
    wait_results_drained();
    tx_gap_max = 0;
    rx_hold_cycles = 400;
    repeat (16) send_cmd(pick_cmd(50), rand_item(), pick_position());
    tx_gap_max = GAP_MAX;
  endtask

  task automatic test_sender_pause();
    repeat (10) send_cmd(pick_cmd(60), rand_item(), pick_position());
    wait_results_drained();
    repeat (10) send_cmd(pick_cmd(40), rand_item(), pick_position());
  endtask

  task automatic test_random_ops();
    int push_pct[6] = '{70, 35, 55, 75, 30, 50};
    int tx_mode[6]  = '{GAP_MAX, 0, GAP_MAX, 0, GAP_MAX, GAP_MAX};
    int rx_mode[6]  = '{GAP_MAX, GAP_MAX, 0, 0, GAP_MAX, GAP_MAX};
    logic [ITEM_W-1:0] empty_vals[6] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
                                         16'h0000};
    for (int p = 0; p < 6; p++) begin
      write_empty_value(p == 5 ? rand_item() : empty_vals[p]);
      tx_gap_max = tx_mode[p];
      rx_gap_max = rx_mode[p];
      for (int i = 0; i < 150; i++) begin
        send_cmd(pick_cmd(push_pct[p]), rand_item(), pick_position());
        if ($urandom_range(0, 99) == 0) wait_results_drained();
      end
    end
    tx_gap_max = GAP_MAX;
    rx_gap_max = GAP_MAX;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_output_stall();
    test_sender_pause();
    test_random_ops();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[indexed_ordered_list_unit] OK");
    end else begin
      $display("[indexed_ordered_list_unit] ERROR");
    end
    $finish;
  end

  // receiver side: random stalls, or one long hold-off when requested
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.data  = out_tdata[15:0];
      got.count = out_tdata[22:16];
      got.front = out_tdata[38:23];
      got.back  = out_tdata[54:39];
      got.mean  = out_tdata[78:55];
      got.ok    = out_tuser;
      if (pending_results.size() == 0) begin
        $error("result word with no command outstanding");
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("data", 32'(want.data), 32'(got.data));
        check_field("ok", 32'(want.ok), 32'(got.ok));
        check_field("count", 32'(want.count), 32'(got.count));
        check_field("front_item", 32'(want.front), 32'(got.front));
        check_field("back_item", 32'(want.back), 32'(got.back));
        check_field("mean_q8", 32'(want.mean), 32'(got.mean));
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[indexed_ordered_list_unit] ERROR");
        $finish;
      end
    end
  end

endmodule
